@@ sv/ird_pkg.sv @@
// shared constants and helpers for the integer to radix digits block
package ird_pkg;

    localparam int MAX_DIGITS = 31;
    localparam int VALUE_W    = 31;
    localparam int BASE_W     = 5;
    localparam int CHAR_W     = 7;
    localparam int COUNT_W    = 5;
    localparam int DIGIT_W    = 4;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W      = $clog2(MAX_DIGITS);
    localparam int STEP_W     = $clog2(VALUE_W + 1);

    localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);

    localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_A    = CHAR_W'(65);

    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        r = b;
        if (b < BASE_MIN)
        begin
            r = BASE_MIN;
        end
        else if (b > BASE_MAX)
        begin
            r = BASE_MAX;
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] r;
        if (d < DIGIT_W'(10))
        begin
            r = CHAR_ZERO + CHAR_W'(d);
        end
        else
        begin
            r = CHAR_A + CHAR_W'(d - DIGIT_W'(10));
        end
        return r;
    endfunction

endpackage

@@ sv/ird_divider.sv @@
// bit-serial restoring divider: one quotient bit per cycle
module ird_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ird_pkg::VALUE_W-1:0]   dividend,
    input  logic [ird_pkg::BASE_W-1:0]    divisor,
    output logic                          done,
    output logic [ird_pkg::VALUE_W-1:0]   quotient,
    output logic [ird_pkg::DIGIT_W-1:0]   remainder
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [ird_pkg::STEP_W-1:0]    step_reg;
    logic [ird_pkg::VALUE_W-1:0]   quot_reg;
    logic [ird_pkg::DIGIT_W-1:0]   rem_reg;
    logic [ird_pkg::BASE_W-1:0]    div_reg;

    logic [ird_pkg::DIGIT_W:0]     trial;
    logic                          ge;
    logic [ird_pkg::DIGIT_W:0]     diff;

    // shift next dividend bit into the partial remainder and try a subtract
    assign trial = {rem_reg, quot_reg[ird_pkg::VALUE_W-1]};
    assign ge    = ({1'b0, trial} >= {{(ird_pkg::BASE_W - ird_pkg::DIGIT_W){1'b0}}, div_reg});
    assign diff  = trial - (ird_pkg::DIGIT_W+1)'(div_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == ird_pkg::STEP_W'(ird_pkg::VALUE_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[ird_pkg::VALUE_W-2:0], ge};
            rem_reg  <= ge ? diff[ird_pkg::DIGIT_W-1:0] : trial[ird_pkg::DIGIT_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

@@ sv/integer_to_radix_digits.sv @@
// integer to ascii radix digits: top level sequencer, digit store and output beat
//
// Converts a 31-bit non-negative value into the ascii digits of its value in a
// base from 2 to 16 ('0'-'9', then 'A'-'F'), most significant digit first, one
// output beat per digit. A base below 2 is taken as 2 and one above 16 as 16.
// A zero value gives the single digit '0'. The final beat carries is_last = 1
// and the total digit count; every other beat has digit_count = 0. The digits
// are found least significant first by a single bit-serial divider and kept in
// a digit store; sending starts once all digits are found. in_ready is
// high only while no item is in flight.
module integer_to_radix_digits (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ird_pkg::VALUE_W-1:0]  value,
    input  logic [ird_pkg::BASE_W-1:0]   base,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ird_pkg::CHAR_W-1:0]   digit_char,
    output logic                         is_last,
    output logic [ird_pkg::COUNT_W-1:0]  digit_count
);

    // sequencer states
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DIV_START = 3'd1;
    localparam logic [2:0] S_DIV_WAIT  = 3'd2;
    localparam logic [2:0] S_READ      = 3'd3;
    localparam logic [2:0] S_SHOW      = 3'd4;

    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;

    // remaining quotient and clamped radix of the current item
    logic [ird_pkg::VALUE_W-1:0]   work_value_reg;
    logic [ird_pkg::BASE_W-1:0]    radix_reg;

    // digits found so far, and index of the digit being sent
    logic [ird_pkg::CNT_W-1:0]     count_reg;
    logic [ird_pkg::CNT_W-1:0]     count_next;
    logic [ird_pkg::IDX_W-1:0]     emit_idx_reg;

    // digit store, least significant digit at index 0
    logic [ird_pkg::DIGIT_W-1:0]   digit_mem [ird_pkg::MAX_DIGITS];
    logic [ird_pkg::DIGIT_W-1:0]   rd_data_reg;

    logic                          div_start;
    logic                          div_done;
    logic [ird_pkg::VALUE_W-1:0]   div_quot;
    logic [ird_pkg::DIGIT_W-1:0]   div_rem;

    logic                          in_beat;
    logic                          out_beat;
    logic                          last_digit;
    logic                          conv_end;

    ird_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (work_value_reg),
        .divisor   (radix_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign in_beat    = in_valid & in_ready;
    assign out_valid  = (state_reg == S_SHOW);
    assign out_beat   = out_valid & out_ready;
    assign div_start  = (state_reg == S_DIV_START);
    assign last_digit = (emit_idx_reg == '0);
    assign count_next = count_reg + 1'b1;

    // stop when the quotient runs out or the store is full
    assign conv_end = (div_quot == '0) ||
                      (count_next == ird_pkg::CNT_W'(ird_pkg::MAX_DIGITS));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = S_DIV_START;
                end
            end
            S_DIV_START:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = conv_end ? S_READ : S_DIV_START;
                end
            end
            S_READ:
            begin
                state_next = S_SHOW;
            end
            S_SHOW:
            begin
                if (out_beat)
                begin
                    state_next = last_digit ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            work_value_reg <= '0;
            radix_reg      <= ird_pkg::BASE_MIN;
            count_reg      <= '0;
            emit_idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_beat)
            begin
                work_value_reg <= value;
                radix_reg      <= ird_pkg::clamp_base(base);
                count_reg      <= '0;
            end
            else if ((state_reg == S_DIV_WAIT) && div_done)
            begin
                count_reg <= count_next;
                if (conv_end)
                begin
                    // most significant digit sits at the highest written index
                    work_value_reg <= '0;
                    emit_idx_reg   <= count_reg[ird_pkg::IDX_W-1:0];
                end
                else
                begin
                    work_value_reg <= div_quot;
                end
            end
            else if (out_beat && !last_digit)
            begin
                emit_idx_reg <= emit_idx_reg - 1'b1;
            end
        end
    end

    // digit store write on each remainder, registered read when sending
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DIV_WAIT) && div_done)
        begin
            digit_mem[count_reg[ird_pkg::IDX_W-1:0]] <= div_rem;
        end
        if (state_reg == S_READ)
        begin
            rd_data_reg <= digit_mem[emit_idx_reg];
        end
    end

    assign digit_char  = ird_pkg::digit_to_ascii(rd_data_reg);
    assign is_last     = last_digit;
    assign digit_count = last_digit ? ird_pkg::COUNT_W'(count_reg) : '0;

endmodule

@@ tb/digit_checker.sv @@
// digit beat checker: predicts the ascii digits of each accepted value and compares beats
module digit_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [ird_pkg::VALUE_W-1:0]  value,
    input  logic [ird_pkg::BASE_W-1:0]   base,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [ird_pkg::CHAR_W-1:0]   digit_char,
    input  logic                         is_last,
    input  logic [ird_pkg::COUNT_W-1:0]  digit_count,
    output int                           mismatch_count,
    output int                           digits_pending
);

    import ird_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic               last;
        logic [COUNT_W-1:0] count;
    } digit_beat_t;

    digit_beat_t expected_digits[$];

    initial
    begin
        mismatch_count = 0;
        digits_pending = 0;
    end

    task automatic log_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // digits are found least significant first, then queued most significant first
    function automatic void predict_digits(input logic [VALUE_W-1:0] v,
                                           input logic [BASE_W-1:0] b);
        logic [VALUE_W-1:0] quot;
        logic [BASE_W-1:0]  rad;
        logic [DIGIT_W-1:0] lsd_first [MAX_DIGITS];
        logic [DIGIT_W-1:0] d;
        digit_beat_t        beat;
        int                 n;
        int                 k;
        rad = b;
        if (b < BASE_MIN)
        begin
            rad = BASE_MIN;
        end
        else if (b > BASE_MAX)
        begin
            rad = BASE_MAX;
        end
        quot = v;
        n = 0;
        do
        begin
            lsd_first[n] = DIGIT_W'(quot % rad);
            n++;
            quot = quot / rad;
        end
        while (quot != 0 && n < MAX_DIGITS);
        for (k = n - 1; k >= 0; k--)
        begin
            d = lsd_first[k];
            if (d < DIGIT_W'(10))
            begin
                beat.ch = CHAR_ZERO + CHAR_W'(d);
            end
            else
            begin
                beat.ch = CHAR_A + CHAR_W'(d) - CHAR_W'(10);
            end
            beat.last  = (k == 0);
            beat.count = (k == 0) ? COUNT_W'(n) : '0;
            expected_digits.push_back(beat);
        end
    endfunction

    always @(posedge clk)
    begin : watch
        digit_beat_t want;
        if (rst_n)
        begin
            if (out_valid === 1'b1 && out_ready)
            begin
                if (expected_digits.size() == 0)
                begin
                    log_mismatch($sformatf("digit beat 0x%h with none expected", digit_char));
                end
                else
                begin
                    want = expected_digits.pop_front();
                    if (digit_char !== want.ch)
                    begin
                        log_mismatch($sformatf("digit_char 0x%h, want 0x%h",
                                               digit_char, want.ch));
                    end
                    if (is_last !== want.last)
                    begin
                        log_mismatch($sformatf("is_last %b, want %b", is_last, want.last));
                    end
                    if (digit_count !== want.count)
                    begin
                        log_mismatch($sformatf("digit_count %0d, want %0d",
                                               digit_count, want.count));
                    end
                end
            end
            if (in_valid && in_ready === 1'b1)
            begin
                predict_digits(value, base);
            end
            digits_pending = expected_digits.size();
        end
    end

endmodule

@@ tb/tb_integer_to_radix_digits.sv @@
// testbench top for integer_to_radix_digits: stimulus, receiver pacing and verdict
module tb_integer_to_radix_digits;

    import ird_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 9;
    // receiver hold-off long enough that the block parks on a digit and stalls its input
    localparam int HOLD_CYCLES    = 600;
    // short tail after the last expected digit to catch any stray beat
    localparam int SETTLE_CYCLES  = 100;
    // watchdog limit for the whole run
    localparam int TIMEOUT_CYCLES = 1500000;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic [VALUE_W-1:0]   value       = '0;
    logic [BASE_W-1:0]    base        = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic [CHAR_W-1:0]    digit_char;
    logic                 is_last;
    logic [COUNT_W-1:0]   digit_count;

    int                   mismatch_count;
    int                   digits_pending;

    // idle percentages for sender and receiver, changed per phase
    int                   src_idle_pct  = 9;
    int                   sink_idle_pct = 59;

    logic                 hold_request  = 1'b0;
    logic                 hold_active   = 1'b0;

    integer_to_radix_digits dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value       (value),
        .base        (base),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digit_char  (digit_char),
        .is_last     (is_last),
        .digit_count (digit_count)
    );

    digit_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .value          (value),
        .base           (base),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digit_char     (digit_char),
        .is_last        (is_last),
        .digit_count    (digit_count),
        .mismatch_count (mismatch_count),
        .digits_pending (digits_pending)
    );

    // free-running clock, rising edge first at half a period
    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // receiver pacing: random stalls, forced low during a hold-off
    always @(negedge clk)
    begin
        out_ready <= !hold_active && ($urandom_range(99) >= sink_idle_pct);
    end

    // one long receiver hold-off, counted on rising edges so the
    // falling-edge ready driver always sees a settled flag
    initial
    begin
        wait (hold_request);
        @(posedge clk);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("FAILURE");
        $finish;
    end

    // present one beat; called and returning at a falling edge.
    // valid is only lowered when the sender actually idles, so back to back
    // beats keep valid high with a single assignment per time step
    task automatic offer_item(input logic [VALUE_W-1:0] v, input logic [BASE_W-1:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            // junk payload while idle, it must be ignored
            value    <= VALUE_W'($urandom);
            base     <= BASE_W'($urandom);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        base     <= b;
        // accepted at the first rising edge that sees ready high
        @(posedge clk);
        while (in_ready !== 1'b1)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // sender pause until every predicted digit has come out
    task automatic wait_for_digits();
        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (digits_pending != 0);
    endtask

    // mostly spread-out magnitudes: full-width values only now and then,
    // so the slow long binary conversions stay rare
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        v = VALUE_W'($urandom) >> $urandom_range(VALUE_W - 1);
        case ($urandom_range(15))
            0: v = '0;
            1: v = VALUE_MAX;
            default: ;
        endcase
        return v;
    endfunction

    // mostly legal radixes, with some out of range ones to hit clamping
    function automatic logic [BASE_W-1:0] random_base();
        logic [BASE_W-1:0] b;
        if ($urandom_range(7) == 0)
        begin
            b = BASE_W'($urandom_range(31));
        end
        else
        begin
            b = BASE_W'($urandom_range(16, 2));
        end
        return b;
    endfunction

    task automatic offer_random(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            offer_item(random_value(), random_base());
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: zero, extremes of value and base, clamping on both sides,
        // letter digits and digit-count boundaries
        offer_item('0, 5'd2);                 // zero gives a single '0'
        offer_item('0, 5'd16);
        offer_item(VALUE_MAX, 5'd2);          // longest result, 31 binary digits
        offer_item(VALUE_MAX, 5'd16);
        offer_item(VALUE_MAX, 5'd10);
        offer_item(VALUE_MAX, 5'd3);
        offer_item(VALUE_MAX, 5'd7);
        offer_item(31'd1, 5'd0);              // base below two taken as two
        offer_item(31'd5, 5'd1);
        offer_item(31'd255, 5'd17);           // base above sixteen taken as sixteen
        offer_item(31'h00ABCDEF, 5'd31);
        offer_item(31'd10, 5'd16);            // single 'A'
        offer_item(31'd15, 5'd16);            // single 'F'
        offer_item(31'd16, 5'd16);            // first two-digit value
        offer_item(31'd9, 5'd10);
        offer_item(31'd1234567890, 5'd10);
        offer_item(31'h2AAAAAAA, 5'd2);
        offer_item(31'h55555555, 5'd4);
        offer_item(31'h7FEDCBA9, 5'd16);
        offer_item(31'd168, 5'd13);           // 'CC' in base 13
        offer_item(31'd224, 5'd15);           // 'EE' in base 15
        wait_for_digits();

        // phase one: light sender idling, heavy receiver stalls, plus a long
        // receiver hold-off while the sender keeps pushing
        offer_random(20);
        hold_request = 1'b1;
        offer_random(77);
        wait_for_digits();

        // phase two: roles swapped
        src_idle_pct  = 59;
        sink_idle_pct = 9;
        offer_random(97);
        wait_for_digits();

        // phase three: full throughput on both sides
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        offer_random(96);

        wait_for_digits();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && digits_pending == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/ird_pkg.sv
sv/ird_divider.sv
sv/integer_to_radix_digits.sv
tb/digit_checker.sv
tb/tb_integer_to_radix_digits.sv
